[rtl/tcce_pkg.sv]
// Shared constants, payload structs and controller/datapath interface types
// for the text console cursor engine. No dependencies.

package tcce_pkg;

   // screen geometry and line editing limits
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int LINE_LIMIT = 128;
   localparam int TAB_WIDTH  = 4;   // power of two
   localparam int CELLS      = ROWS * COLUMNS;

   localparam int KIND_W    = 3;
   localparam int CODE_W    = 8;
   localparam int ADDR_W    = 11;
   localparam int COL_W     = 7;
   localparam int ROW_W     = 5;
   localparam int COUNT_W   = 8;
   localparam int ATTR_W    = 8;
   localparam int CSR_IDX_W = 1;
   localparam int TAB_CNT_W = $clog2(TAB_WIDTH + 1);

   localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TYPE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TAB   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BACK  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ENTER = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd5;

   localparam logic [CODE_W-1:0] NUL_CODE     = 8'h00;
   localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [CODE_W-1:0] CR_CODE      = 8'h0D;
   localparam logic [CODE_W-1:0] SPACE_CODE   = 8'h20;

   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
   localparam logic [CODE_W-1:0] IGNORE_RESET = 8'h00;

   localparam logic [CSR_IDX_W-1:0] CSR_ATTR   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE = 1'b1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CODE_W-1:0] code;
      logic [ADDR_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]   cursor_col;
      logic [ROW_W-1:0]   cursor_row;
      logic [ADDR_W-1:0]  cursor_linear;
      logic [COUNT_W-1:0] typed_count;
      logic               accepted;
      logic               scrolled;
      logic [CODE_W-1:0]  read_char;
      logic [ATTR_W-1:0]  read_attr;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clear_wr;
      logic step;
      logic scroll_start;
      logic scroll_wr;
      logic read_cap;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_last;
      logic step_scroll;
      logic step_read;
      logic tab_more;
      logic tab_left;
      logic rsp_free;
   } status_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS));
      return ADDR_W'(base + ADDR_W'(col));
   endfunction

   function automatic logic [TAB_CNT_W-1:0] tab_pad(input logic [COL_W-1:0] col);
      logic [COL_W-1:0] rem;
      rem = col % COL_W'(TAB_WIDTH);
      return TAB_CNT_W'(TAB_WIDTH) - TAB_CNT_W'(rem);
   endfunction

endpackage

[rtl/tcce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module tcce_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 2000,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff <= mem_ff[raddr];
   end

   assign rdata = rd_ff;

endmodule

[rtl/tcce_ctrl.sv]
// Sequencer for the console engine: clearing pass, item steps, scroll sweep,
// read wait and result hand-off. Depends on tcce_pkg.

module tcce_ctrl
   import tcce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR        = 7'b0000001,
      ST_IDLE         = 7'b0000010,
      ST_STEP         = 7'b0000100,
      ST_SCROLL_PRIME = 7'b0001000,
      ST_SCROLL       = 7'b0010000,
      ST_READ_WAIT    = 7'b0100000,
      ST_FINISH       = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (status.step_scroll) begin
               state_in = ST_SCROLL_PRIME;
            end else if (status.step_read) begin
               state_in = ST_READ_WAIT;
            end else if (status.tab_more) begin
               state_in = ST_STEP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCROLL_PRIME: begin
            cmd.scroll_start = 1'b1;
            state_in = ST_SCROLL;
         end
         ST_SCROLL: begin
            cmd.scroll_wr = 1'b1;
            if (status.sweep_last) begin
               // resume remaining tab spaces after the scroll
               state_in = status.tab_left ? ST_STEP : ST_FINISH;
            end
         end
         ST_READ_WAIT: begin
            cmd.read_cap = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

[rtl/tcce_dp.sv]
// Datapath of the console engine: cursor, typed count, config registers,
// character and attribute memories, sweep pointer and result register.
// Depends on tcce_pkg and tcce_ram.

module tcce_dp
   import tcce_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  req_type              req_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ATTR_W-1:0]    csr_wr_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output rsp_type              rsp_data
);

   logic [ATTR_W-1:0]    attr_byte_ff, attr_byte_in;
   logic [CODE_W-1:0]    ignored_ff, ignored_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic [ADDR_W-1:0]    cell_ff, cell_in;
   logic [TAB_CNT_W-1:0] tab_n_ff, tab_n_in;
   logic                 scrolled_ff, scrolled_in;
   logic                 accepted_ff, accepted_in;
   logic [CODE_W-1:0]    rd_char_ff, rd_char_in;
   logic [ATTR_W-1:0]    rd_attr_ff, rd_attr_in;
   logic [ADDR_W-1:0]    ptr_ff, ptr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic              char_we, attr_we;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [CODE_W-1:0] char_wdata, char_rdata;
   logic [ATTR_W-1:0] attr_wdata, attr_rdata;

   // step decode
   logic              typed_ok, do_print, count_inc, count_clr;
   logic [CODE_W-1:0] pc;
   logic              prt, is_nl, wr_print, advance_row, step_scroll;
   logic              last_col, last_row;
   logic              bs_ok;
   logic [COL_W-1:0]  bs_col;
   logic [ROW_W-1:0]  bs_row;
   logic [ADDR_W-1:0] cur_addr, bs_addr;
   logic [ADDR_W:0]   ahead;
   logic              cell_in_range;

   always_comb begin
      typed_ok  = count_ff < COUNT_W'(LINE_LIMIT - 1);
      do_print  = 1'b0;
      count_inc = 1'b0;
      count_clr = 1'b0;
      pc        = code_ff;
      case (kind_ff)
         KIND_WRITE: begin
            do_print = 1'b1;
         end
         KIND_TYPE: begin
            do_print  = typed_ok;
            count_inc = typed_ok;
         end
         KIND_TAB: begin
            pc        = SPACE_CODE;
            do_print  = typed_ok && (tab_n_ff != '0);
            count_inc = do_print;
         end
         KIND_ENTER: begin
            pc        = NEWLINE_CODE;
            do_print  = 1'b1;
            count_clr = 1'b1;
         end
         default: begin
            do_print = 1'b0;
         end
      endcase

      prt         = do_print && (pc != ignored_ff) && (pc != NUL_CODE) && (pc != CR_CODE);
      is_nl       = (pc == NEWLINE_CODE);
      wr_print    = prt && !is_nl;
      last_col    = (col_ff == COL_W'(COLUMNS - 1));
      last_row    = (row_ff == ROW_W'(ROWS - 1));
      advance_row = prt && (is_nl || last_col);
      step_scroll = advance_row && last_row;

      bs_ok  = (kind_ff == KIND_BACK) && (count_ff != '0)
               && !((col_ff == '0) && (row_ff == '0));
      bs_col = (col_ff != '0) ? col_ff - COL_W'(1) : COL_W'(COLUMNS - 1);
      bs_row = (col_ff != '0) ? row_ff : row_ff - ROW_W'(1);

      cur_addr      = cell_addr(row_ff, col_ff);
      bs_addr       = cell_addr(bs_row, bs_col);
      ahead         = {1'b0, ptr_ff} + (ADDR_W + 1)'(COLUMNS + 1);
      cell_in_range = cell_ff < ADDR_W'(CELLS);
   end

   // memory ports
   always_comb begin
      char_we    = 1'b0;
      attr_we    = 1'b0;
      waddr      = cur_addr;
      char_wdata = pc;
      attr_wdata = attr_byte_ff;
      raddr      = cell_in_range ? cell_ff : '0;
      if (cmd.clear_wr) begin
         char_we    = 1'b1;
         attr_we    = 1'b1;
         waddr      = ptr_ff;
         char_wdata = '0;
         attr_wdata = '0;
      end else if (cmd.scroll_start) begin
         raddr = ADDR_W'(COLUMNS);
      end else if (cmd.scroll_wr) begin
         // move characters up one row, blank the bottom row; attributes stay
         char_we    = 1'b1;
         waddr      = ptr_ff;
         char_wdata = (ptr_ff < ADDR_W'(CELLS - COLUMNS)) ? char_rdata : SPACE_CODE;
         raddr      = (ahead < (ADDR_W + 1)'(CELLS)) ? ADDR_W'(ahead) : '0;
      end else if (cmd.step) begin
         if (bs_ok) begin
            char_we    = 1'b1;
            attr_we    = 1'b1;
            waddr      = bs_addr;
            char_wdata = SPACE_CODE;
         end else if (wr_print) begin
            char_we = 1'b1;
            attr_we = 1'b1;
         end
      end
   end

   tcce_ram #(.WIDTH(CODE_W), .DEPTH(CELLS)) u_char_ram (
      .clock (clock),
      .we    (char_we),
      .waddr (waddr),
      .wdata (char_wdata),
      .raddr (raddr),
      .rdata (char_rdata)
   );

   tcce_ram #(.WIDTH(ATTR_W), .DEPTH(CELLS)) u_attr_ram (
      .clock (clock),
      .we    (attr_we),
      .waddr (waddr),
      .wdata (attr_wdata),
      .raddr (raddr),
      .rdata (attr_rdata)
   );

   // next state
   always_comb begin
      attr_byte_in = attr_byte_ff;
      ignored_in   = ignored_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      count_in     = count_ff;
      kind_in      = kind_ff;
      code_in      = code_ff;
      cell_in      = cell_ff;
      tab_n_in     = tab_n_ff;
      scrolled_in  = scrolled_ff;
      accepted_in  = accepted_ff;
      rd_char_in   = rd_char_ff;
      rd_attr_in   = rd_attr_ff;
      ptr_in       = ptr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_ATTR:   attr_byte_in = csr_wr_data;
            CSR_IGNORE: ignored_in   = csr_wr_data;
            default:    attr_byte_in = attr_byte_ff;
         endcase
      end

      if (cmd.load) begin
         kind_in     = req_data.kind;
         code_in     = req_data.code;
         cell_in     = req_data.cell_index;
         tab_n_in    = tab_pad(col_ff);
         scrolled_in = 1'b0;
         accepted_in = 1'b0;
         rd_char_in  = '0;
         rd_attr_in  = '0;
      end

      if (cmd.clear_wr || cmd.scroll_wr) begin
         ptr_in = ptr_ff + ADDR_W'(1);
      end
      if (cmd.scroll_start) begin
         ptr_in = '0;
      end

      if (cmd.step) begin
         if (bs_ok) begin
            col_in   = bs_col;
            row_in   = bs_row;
            count_in = count_ff - COUNT_W'(1);
         end else if (prt) begin
            if (advance_row) begin
               col_in = '0;
               // at the bottom the scroll sweep makes room; hold the row
               row_in = last_row ? row_ff : row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         if (count_clr) begin
            count_in = '0;
         end else if (count_inc) begin
            count_in = count_ff + COUNT_W'(1);
         end
         if ((kind_ff == KIND_TAB) && (tab_n_ff != '0)) begin
            tab_n_in = tab_n_ff - TAB_CNT_W'(1);
         end
         if (kind_ff == KIND_TYPE) begin
            accepted_in = typed_ok;
         end
         if (step_scroll) begin
            scrolled_in = 1'b1;
         end
      end

      if (cmd.read_cap) begin
         rd_char_in = char_rdata;
         rd_attr_in = attr_rdata;
      end

      if (cmd.rsp_load) begin
         rsp_in.cursor_col    = col_ff;
         rsp_in.cursor_row    = row_ff;
         rsp_in.cursor_linear = cur_addr;
         rsp_in.typed_count   = count_ff;
         rsp_in.accepted      = accepted_ff;
         rsp_in.scrolled      = scrolled_ff;
         rsp_in.read_char     = rd_char_ff;
         rsp_in.read_attr     = rd_attr_ff;
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_byte_ff <= ATTR_RESET;
         ignored_ff   <= IGNORE_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         tab_n_ff     <= '0;
         scrolled_ff  <= 1'b0;
         accepted_ff  <= 1'b0;
      end else begin
         attr_byte_ff <= attr_byte_in;
         ignored_ff   <= ignored_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         tab_n_ff     <= tab_n_in;
         scrolled_ff  <= scrolled_in;
         accepted_ff  <= accepted_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      code_ff    <= code_in;
      cell_ff    <= cell_in;
      rd_char_ff <= rd_char_in;
      rd_attr_ff <= rd_attr_in;
      rsp_ff     <= rsp_in;
   end

   assign status.sweep_last  = (ptr_ff == ADDR_W'(CELLS - 1));
   assign status.step_scroll = step_scroll;
   assign status.step_read   = (kind_ff == KIND_READ) && cell_in_range;
   assign status.tab_more    = (kind_ff == KIND_TAB) && (tab_n_ff > TAB_CNT_W'(1));
   assign status.tab_left    = (kind_ff == KIND_TAB) && (tab_n_ff != '0);
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/text_console_cursor_engine.sv]
// Top level of the text console cursor and scroll engine.
// Depends on tcce_pkg, tcce_ctrl, tcce_dp (and tcce_ram through tcce_dp).
//
//   channel | direction | handshake                  | payload
//   req_    | in        | req_valid / req_stall      | req_data (kind, code, cell_index)
//   rsp_    | out       | rsp_valid / rsp_stall      | rsp_data (cursor, count, flags, cell)
//   csr_    | in        | csr_wr_en, no wait         | csr_index, csr_wr_data
//
// One item at a time: an item is taken in the idle state, goes through the step state, and
// its result is loaded in the finish state once the output register is free. A cell read
// in range adds a read wait state, a tab a step per space, up to TAB_WIDTH; then back to idle.
// Each scroll adds a priming state and a sweep over all ROWS*COLUMNS cells: the sweep moves
// one character per cycle through the single write port of the character memory.
// After reset a clearing pass over all ROWS*COLUMNS cells zeroes both memories;
// req_stall stays high meanwhile. Config writes are taken at any time.
// A finished result waits in the output register while the next item is taken.

module text_console_cursor_engine
   import tcce_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ATTR_W-1:0]    csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcce_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

[rtl/tcce_checker.sv]
// Port-level checks for the console engine, bound to the top level.
// Depends on tcce_pkg.

module tcce_checker
   import tcce_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a held result must not change under stall
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // clearing pass after reset takes no item
   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("item taken during clearing pass");

   a_linear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cursor_linear
                    == cell_addr(rsp_data.cursor_row, rsp_data.cursor_col))
      else $error("cursor_linear does not match row and column");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.cursor_col < COL_W'(COLUMNS))
                    && (rsp_data.cursor_row < ROW_W'(ROWS))
                    && (rsp_data.typed_count < COUNT_W'(LINE_LIMIT)))
      else $error("cursor or count out of range");

   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.scrolled |-> rsp_data.cursor_row == ROW_W'(ROWS - 1))
      else $error("scroll left cursor off the bottom row");

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[tb/text_console_cursor_engine_test.sv]
// Self-checking testbench for text_console_cursor_engine: directed and random console
// traffic over the req_/rsp_ channels, with a behavioral screen model in the bench.
// Depends on tcce_pkg and the RTL of the engine; needs no other files.
`timescale 1ns / 1ps

module text_console_cursor_engine_test;
   import tcce_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
   localparam longint RUN_LIMIT_NS = 64'd60_000_000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ATTR_W-1:0]    csr_wr_data = '0;

   // screen model
   logic [CODE_W-1:0] screen_char [CELLS] = '{default: 8'h00};
   logic [ATTR_W-1:0] screen_attr [CELLS] = '{default: 8'h00};
   int                cur_col = 0;
   int                cur_row = 0;
   int                line_len = 0;
   logic [ATTR_W-1:0] attr_reg = ATTR_RESET;
   logic [CODE_W-1:0] ignore_reg = IGNORE_RESET;
   bit                scroll_seen;

   rsp_type     cursor_report_q [$];
   int          mismatch_count = 0;
   bit          req_gaps_on = 1'b1;
   bit          rsp_gaps_on = 1'b1;
   int unsigned rsp_hold_left = 0;
   int unsigned rsp_hold_draw;

   text_console_cursor_engine DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int cursor_cell();
      return cur_row * COLUMNS + cur_col;
   endfunction

   // characters move up, attributes stay, bottom row goes blank
   function automatic void shift_screen_up();
      for (int i = COLUMNS; i < CELLS; i++) screen_char[i - COLUMNS] = screen_char[i];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_char[i] = SPACE_CODE;
      cur_col = 0;
      cur_row = ROWS - 1;
      scroll_seen = 1'b1;
   endfunction

   function automatic void put_code(input logic [CODE_W-1:0] c);
      int at;
      if (c == ignore_reg || c == NUL_CODE || c == CR_CODE) return;
      if (c == NEWLINE_CODE) begin
         cur_row++;
         cur_col = 0;
         if (cur_row >= ROWS) shift_screen_up();
         return;
      end
      at = cursor_cell();
      screen_char[at] = c;
      screen_attr[at] = attr_reg;
      cur_col++;
      if (cur_col >= COLUMNS) begin
         cur_row++;
         cur_col = 0;
      end
      if (cur_row >= ROWS) shift_screen_up();
   endfunction

   function automatic bit type_into_line(input logic [CODE_W-1:0] c);
      if (line_len >= LINE_LIMIT - 1) return 1'b0;
      line_len++;
      put_code(c);
      return 1'b1;
   endfunction

   function automatic rsp_type console_step(input req_type item);
      rsp_type r;
      int      pad;
      int      at;
      r = '0;
      scroll_seen = 1'b0;
      case (item.kind)
         KIND_WRITE: put_code(item.code);
         KIND_TYPE: r.accepted = type_into_line(item.code);
         KIND_TAB: begin
            pad = TAB_WIDTH - (cur_col % TAB_WIDTH);
            repeat (pad) void'(type_into_line(SPACE_CODE));
         end
         KIND_BACK: begin
            if (line_len != 0 && !(cur_col == 0 && cur_row == 0)) begin
               line_len--;
               if (cur_col >= 1) begin
                  cur_col--;
               end else begin
                  cur_col = COLUMNS - 1;
                  cur_row--;
               end
               at = cursor_cell();
               screen_char[at] = SPACE_CODE;
               screen_attr[at] = attr_reg;
            end
         end
         KIND_ENTER: begin
            put_code(NEWLINE_CODE);
            line_len = 0;
         end
         KIND_READ: begin
            if (item.cell_index < CELLS) begin
               r.read_char = screen_char[item.cell_index];
               r.read_attr = screen_attr[item.cell_index];
            end
         end
         default: ;
      endcase
      r.cursor_col    = COL_W'(cur_col);
      r.cursor_row    = ROW_W'(cur_row);
      r.cursor_linear = ADDR_W'(cursor_cell());
      r.typed_count   = COUNT_W'(line_len);
      r.scrolled      = scroll_seen;
      return r;
   endfunction

   function automatic void check_field(input string field, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
      end
   endfunction

   function automatic void check_report(input rsp_type got);
      rsp_type want;
      if (cursor_report_q.size() == 0) begin
         mismatch_count++;
         $display("%0t ns: result expected none actual %h", $time, got);
         return;
      end
      want = cursor_report_q.pop_front();
      check_field("cursor_col", want.cursor_col, got.cursor_col);
      check_field("cursor_row", want.cursor_row, got.cursor_row);
      check_field("cursor_linear", want.cursor_linear, got.cursor_linear);
      check_field("typed_count", want.typed_count, got.typed_count);
      check_field("accepted", want.accepted, got.accepted);
      check_field("scrolled", want.scrolled, got.scrolled);
      check_field("read_char", want.read_char, got.read_char);
      check_field("read_attr", want.read_attr, got.read_attr);
   endfunction

   // result side: check each item taken, then hold off for a random count
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         check_report(rsp_data);
         rsp_hold_draw = rsp_gaps_on ? $urandom_range(0, 11) : 0;
         rsp_hold_left <= rsp_hold_draw;
         rsp_stall <= (rsp_hold_draw != 0);
      end else if (rsp_hold_left > 1) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_hold_left <= 0;
         rsp_stall <= 1'b0;
      end
   end

   function automatic req_type make_item(input logic [KIND_W-1:0] kind,
                                         input logic [CODE_W-1:0] code,
                                         input logic [ADDR_W-1:0] cell_idx);
      req_type item;
      item.kind = kind;
      item.code = code;
      item.cell_index = cell_idx;
      return item;
   endfunction

   function automatic logic [CODE_W-1:0] pick_code();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return CODE_W'($urandom_range(8'h21, 8'h7E));
      if (roll < 76) return NEWLINE_CODE;
      if (roll < 80) return CR_CODE;
      if (roll < 84) return NUL_CODE;
      if (roll < 88) return ignore_reg;
      if (roll < 92) return SPACE_CODE;
      return CODE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [ADDR_W-1:0] pick_cell();
      int unsigned roll;
      int unsigned here;
      roll = $urandom_range(0, 99);
      here = cursor_cell();
      if (roll < 40) return ADDR_W'(here > 3 ? here - $urandom_range(0, 3) : here);
      if (roll < 80) return ADDR_W'($urandom_range(0, CELLS - 1));
      if (roll < 92) return ADDR_W'($urandom_range(CELLS - COLUMNS, CELLS - 1));
      return ADDR_W'($urandom_range(CELLS, 2 ** ADDR_W - 1));
   endfunction

   function automatic req_type random_item();
      int unsigned     roll;
      logic [KIND_W-1:0] kind;
      roll = $urandom_range(0, 99);
      if (roll < 30) kind = KIND_WRITE;
      else if (roll < 58) kind = KIND_TYPE;
      else if (roll < 64) kind = KIND_TAB;
      else if (roll < 74) kind = KIND_BACK;
      else if (roll < 82) kind = KIND_ENTER;
      else if (roll < 97) kind = KIND_READ;
      else if (roll < 99) kind = KIND_SPARE_A;
      else kind = KIND_SPARE_B;
      return make_item(kind, pick_code(), pick_cell());
   endfunction

   // valid is left high on return; the caller sends again or drains in the same step
   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = req_gaps_on ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cursor_report_q.push_back(console_step(item));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (cursor_report_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [ATTR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      if (idx == CSR_ATTR) attr_reg = value;
      else ignore_reg = value;
   endtask

   task automatic apply_config(input logic [ATTR_W-1:0] attr, input logic [CODE_W-1:0] ign);
      drain_results();
      write_reg(CSR_ATTR, attr);
      write_reg(CSR_IGNORE, ign);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_edit_basics();
      send_item(make_item(KIND_BACK, 8'h00, 11'd0));
      send_item(make_item(KIND_READ, 8'hFF, 11'd0));
      send_item(make_item(KIND_TYPE, 8'h41, 11'd0));
      send_item(make_item(KIND_BACK, 8'h00, 11'd0));
      send_item(make_item(KIND_BACK, 8'h00, 11'd0));
      send_item(make_item(KIND_WRITE, 8'hFF, 11'd0));
      send_item(make_item(KIND_WRITE, NUL_CODE, 11'd0));
      send_item(make_item(KIND_WRITE, CR_CODE, 11'd0));
      send_item(make_item(KIND_WRITE, NEWLINE_CODE, 11'd0));
      send_item(make_item(KIND_TAB, 8'h00, 11'd0));
      send_item(make_item(KIND_TYPE, 8'h7E, 11'd0));
      send_item(make_item(KIND_TAB, 8'h00, 11'd0));
      send_item(make_item(KIND_TYPE, NEWLINE_CODE, 11'd0));
      // back over the row start into the last column above
      send_item(make_item(KIND_BACK, 8'h00, 11'd0));
      send_item(make_item(KIND_READ, 8'h00, 11'd2047));
      send_item(make_item(KIND_READ, 8'h00, 11'd1999));
      send_item(make_item(KIND_READ, 8'h00, 11'd1));
      send_item(make_item(KIND_READ, 8'h00, 11'd80));
      send_item(make_item(KIND_READ, 8'h00, 11'd159));
      send_item(make_item(KIND_SPARE_A, 8'hFF, 11'd2047));
      send_item(make_item(KIND_SPARE_B, 8'h00, 11'd0));
      send_item(make_item(KIND_ENTER, 8'h00, 11'd0));
      send_item(make_item(KIND_TYPE, 8'h80, 11'd0));
   endtask

   task automatic test_register_settings();
      apply_config(8'hFF, 8'h41);
      send_item(make_item(KIND_WRITE, 8'h41, 11'd0));
      send_item(make_item(KIND_TYPE, 8'h41, 11'd0));
      send_item(make_item(KIND_WRITE, 8'h42, 11'd0));
      send_item(make_item(KIND_READ, 8'h00, ADDR_W'(cursor_cell() - 1)));
      apply_config(8'h00, NEWLINE_CODE);
      send_item(make_item(KIND_ENTER, 8'h00, 11'd0));
      send_item(make_item(KIND_TYPE, NEWLINE_CODE, 11'd0));
      send_item(make_item(KIND_WRITE, NEWLINE_CODE, 11'd0));
      send_item(make_item(KIND_WRITE, 8'h43, 11'd0));
      send_item(make_item(KIND_BACK, 8'h00, 11'd0));
      send_item(make_item(KIND_READ, 8'h00, ADDR_W'(cursor_cell())));
      apply_config(ATTR_W'($urandom_range(1, 254)), SPACE_CODE);
      send_item(make_item(KIND_TAB, 8'h00, 11'd0));
      send_item(make_item(KIND_WRITE, SPACE_CODE, 11'd0));
      apply_config(8'h07, 8'hFF);
      send_item(make_item(KIND_WRITE, 8'hFF, 11'd0));
      send_item(make_item(KIND_WRITE, 8'hFE, 11'd0));
      send_item(make_item(KIND_READ, 8'h00, ADDR_W'(cursor_cell() - 1)));
   endtask

   task automatic test_scroll_bottom();
      apply_config(8'h17, 8'h00);
      req_gaps_on = 1'b0;
      while (cur_row < ROWS - 1) send_item(make_item(KIND_ENTER, 8'h00, 11'd0));
      req_gaps_on = 1'b1;
      send_item(make_item(KIND_WRITE, 8'h5A, 11'd0));
      send_item(make_item(KIND_ENTER, 8'h00, 11'd0));
      send_item(make_item(KIND_READ, 8'h00, ADDR_W'(CELLS - 2 * COLUMNS)));
      send_item(make_item(KIND_READ, 8'h00, ADDR_W'(CELLS - COLUMNS)));
      send_item(make_item(KIND_TYPE, 8'h61, 11'd0));
      send_item(make_item(KIND_TYPE, NEWLINE_CODE, 11'd0));
      send_item(make_item(KIND_WRITE, NEWLINE_CODE, 11'd0));
      send_item(make_item(KIND_READ, 8'h00, ADDR_W'(CELLS - 3 * COLUMNS)));
   endtask

   // type past the line limit, with tabs mixed in, then back up and end the line
   task automatic test_full_line();
      int unsigned roll;
      apply_config(8'h1E, 8'h00);
      for (int n = 0; n < 132; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 6) send_item(make_item(KIND_TAB, pick_code(), pick_cell()));
         else if (roll < 10) send_item(make_item(KIND_READ, pick_code(), pick_cell()));
         else send_item(make_item(KIND_TYPE, pick_code(), pick_cell()));
      end
      send_item(make_item(KIND_TAB, 8'h00, 11'd0));
      send_item(make_item(KIND_TYPE, 8'h7A, 11'd0));
      repeat ($urandom_range(35, 50)) send_item(make_item(KIND_BACK, pick_code(), pick_cell()));
      send_item(make_item(KIND_ENTER, 8'h00, 11'd0));
   endtask

   task automatic test_random_console();
      for (int n = 0; n < 120; n++) begin
         if (n % 16 == 0) begin
            req_gaps_on = ($urandom_range(0, 3) != 0);
            rsp_gaps_on = ($urandom_range(0, 3) != 0);
         end
         if (n == 60) apply_config(ATTR_W'($urandom_range(0, 255)),
                                   CODE_W'($urandom_range(8'h80, 8'hFF)));
         else if ($urandom_range(0, 39) == 0) drain_results();
         send_item(random_item());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_edit_basics();
      test_register_settings();
      test_scroll_bottom();
      test_full_line();
      test_random_console();
      drain_results();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[sim.f]
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/tcce_ctrl.sv
rtl/tcce_dp.sv
rtl/text_console_cursor_engine.sv
rtl/tcce_checker.sv
tb/text_console_cursor_engine_test.sv
